[src/mcet_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcet_pkg - media changer element table package
// Shared constants, codes and transfer types for the element table block.
// ----------------------------------------------------------------------------
package mcet_pkg;

   // table geometry
   localparam int MAX_SLOTS     = 64;
   localparam int MAX_DRIVES    = 8;
   localparam int MAX_MAILSLOTS = 8;
   localparam int DRIVE_BASE    = 1000;
   localparam int MAIL_BASE     = 2000;
   localparam int SLOT_LIMIT    = 1000;

   // unified element index: slots first, then drives, then mailslots
   localparam int DRIVE_OFS  = MAX_SLOTS;
   localparam int MAIL_OFS   = MAX_SLOTS + MAX_DRIVES;
   localparam int ELEM_DEPTH = MAX_SLOTS + MAX_DRIVES + MAX_MAILSLOTS;
   localparam int ELEM_W     = $clog2(ELEM_DEPTH);

   // field widths
   localparam int CMD_W      = 3;
   localparam int ADDR_W     = 16;
   localparam int TAPE_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int SLOT_CNT_W = 7;
   localparam int UNIT_CNT_W = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAILS  = 2'd2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PLACE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVAL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOMED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] src_elem;
      logic [ADDR_W-1:0] dst_elem;
      logic [TAPE_W-1:0] tape_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                full_res;
      logic [TAPE_W-1:0]   tape_out;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;   // capture request, read table
      logic exec;   // evaluate, update table, post result
   } ctl_type;

   // decoded element address
   typedef struct packed {
      logic              ok;
      logic              is_slot;
      logic [ELEM_W-1:0] idx;
   } elem_dec_type;

endpackage

`default_nettype wire

[src/mcet_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcet_ctrl - element table controller
// Two-state sequencer: capture a command, then execute it.
// ----------------------------------------------------------------------------
module mcet_ctrl
   import mcet_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output ctl_type      ctl
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff == ST_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[src/mcet_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcet_dp - element table datapath
// Address decode, config registers, full bits, tape memory and result register.
// ----------------------------------------------------------------------------
module mcet_dp
   import mcet_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctl_type               ctl,
   input  wire req_type               req_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data
);

   // config registers
   logic [SLOT_CNT_W-1:0] slots_ff;
   logic [UNIT_CNT_W-1:0] drives_ff;
   logic [UNIT_CNT_W-1:0] mails_ff;

   // saturated counts
   logic [SLOT_CNT_W-1:0] n_slots;
   logic [UNIT_CNT_W-1:0] n_drives;
   logic [UNIT_CNT_W-1:0] n_mails;

   // table
   logic [ELEM_DEPTH-1:0] full_ff;
   logic [ELEM_DEPTH-1:0] full_in;
   logic [TAPE_W-1:0]     tape_mem [ELEM_DEPTH];

   // captured request
   logic [CMD_W-1:0]  cmd_ff;
   elem_dec_type      src_ff;
   elem_dec_type      dst_ff;
   logic [TAPE_W-1:0] tape_ff;
   logic [TAPE_W-1:0] rd_tape_ff;

   elem_dec_type      src_dec;
   elem_dec_type      dst_dec;
   logic [ELEM_W-1:0] rd_addr;

   logic              mem_we;
   logic [ELEM_W-1:0] mem_wa;
   logic [TAPE_W-1:0] mem_wd;
   logic              src_full;
   logic              dst_full;
   rsp_type           rsp_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   function automatic elem_dec_type decode_elem(
      input logic [ADDR_W-1:0]     addr,
      input logic [SLOT_CNT_W-1:0] ns,
      input logic [UNIT_CNT_W-1:0] nd,
      input logic [UNIT_CNT_W-1:0] nm
   );
      elem_dec_type      r;
      logic [ADDR_W-1:0] off;
      r   = '0;
      off = '0;
      if (addr < ADDR_W'(SLOT_LIMIT)) begin
         r.ok      = (addr < ADDR_W'(ns));
         r.is_slot = r.ok;
         r.idx     = addr[ELEM_W-1:0];
      end else if (addr < ADDR_W'(MAIL_BASE)) begin
         off   = addr - ADDR_W'(DRIVE_BASE);
         r.ok  = (addr >= ADDR_W'(DRIVE_BASE)) && (off < ADDR_W'(nd));
         r.idx = ELEM_W'(DRIVE_OFS) + off[ELEM_W-1:0];
      end else begin
         off   = addr - ADDR_W'(MAIL_BASE);
         r.ok  = (off < ADDR_W'(nm));
         r.idx = ELEM_W'(MAIL_OFS) + off[ELEM_W-1:0];
      end
      return r;
   endfunction

   assign n_slots  = (slots_ff > SLOT_CNT_W'(MAX_SLOTS)) ? SLOT_CNT_W'(MAX_SLOTS) : slots_ff;
   assign n_drives = (drives_ff > UNIT_CNT_W'(MAX_DRIVES)) ? UNIT_CNT_W'(MAX_DRIVES) : drives_ff;
   assign n_mails  = (mails_ff > UNIT_CNT_W'(MAX_MAILSLOTS)) ?
                     UNIT_CNT_W'(MAX_MAILSLOTS) : mails_ff;

   assign src_dec = decode_elem(req_data.src_elem, n_slots, n_drives, n_mails);
   assign dst_dec = decode_elem(req_data.dst_elem, n_slots, n_drives, n_mails);
   // place reads its slot, everything else reads the source
   assign rd_addr = (req_data.cmd == CMD_PLACE) ? dst_dec.idx : src_dec.idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff  <= SLOT_CNT_W'(MAX_SLOTS);
         drives_ff <= UNIT_CNT_W'(MAX_DRIVES);
         mails_ff  <= UNIT_CNT_W'(MAX_MAILSLOTS);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLOTS:  slots_ff  <= csr_wdata[SLOT_CNT_W-1:0];
            CSR_DRIVES: drives_ff <= csr_wdata[UNIT_CNT_W-1:0];
            CSR_MAILS:  mails_ff  <= csr_wdata[UNIT_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff     <= req_data.cmd;
         src_ff     <= src_dec;
         dst_ff     <= dst_dec;
         tape_ff    <= req_data.tape_id;
         rd_tape_ff <= tape_mem[rd_addr];
      end
      if (mem_we) begin
         tape_mem[mem_wa] <= mem_wd;
      end
   end

   assign src_full = full_ff[src_ff.idx];
   assign dst_full = full_ff[dst_ff.idx];

   always_comb begin
      full_in = full_ff;
      mem_we  = 1'b0;
      mem_wa  = dst_ff.idx;
      mem_wd  = rd_tape_ff;
      rsp_in  = '{status: ST_INVAL, full_res: 1'b0, tape_out: '0};
      if (ctl.exec) begin
         case (cmd_ff)
            CMD_MOVE: begin
               if (!src_ff.ok) begin
                  rsp_in.status = ST_INVAL;
               end else if (!src_full) begin
                  rsp_in.status = ST_NOMED;
               end else if (!dst_ff.ok) begin
                  rsp_in.status = ST_INVAL;
               end else if (dst_ff.idx == src_ff.idx) begin
                  rsp_in = '{status: ST_OK, full_res: 1'b1, tape_out: rd_tape_ff};
               end else if (dst_full) begin
                  rsp_in.status = ST_BUSY;
               end else begin
                  full_in[src_ff.idx] = 1'b0;
                  full_in[dst_ff.idx] = 1'b1;
                  mem_we = 1'b1;
                  rsp_in = '{status: ST_OK, full_res: 1'b1, tape_out: rd_tape_ff};
               end
            end
            CMD_REMOVE: begin
               if (!src_ff.ok) begin
                  rsp_in.status = ST_INVAL;
               end else if (!src_full) begin
                  rsp_in.status = ST_NOMED;
               end else begin
                  full_in[src_ff.idx] = 1'b0;
                  rsp_in = '{status: ST_OK, full_res: 1'b0, tape_out: rd_tape_ff};
               end
            end
            CMD_PLACE: begin
               if (!dst_ff.is_slot || (tape_ff == '0)) begin
                  rsp_in.status = ST_INVAL;
               end else if (dst_full && (rd_tape_ff != tape_ff)) begin
                  rsp_in.status = ST_BUSY;
               end else begin
                  full_in[dst_ff.idx] = 1'b1;
                  mem_we = 1'b1;
                  mem_wd = tape_ff;
                  rsp_in.status = ST_OK;
               end
            end
            CMD_CLEAR: begin
               // only entries inside the active counts are emptied
               for (int i = 0; i < ELEM_DEPTH; i++) begin
                  if (i < MAX_SLOTS) begin
                     if (i < int'(n_slots)) full_in[i] = 1'b0;
                  end else if (i < MAIL_OFS) begin
                     if ((i - DRIVE_OFS) < int'(n_drives)) full_in[i] = 1'b0;
                  end else begin
                     if ((i - MAIL_OFS) < int'(n_mails)) full_in[i] = 1'b0;
                  end
               end
               rsp_in.status = ST_OK;
            end
            CMD_QUERY: begin
               if (!src_ff.ok) begin
                  rsp_in.status = ST_INVAL;
               end else begin
                  rsp_in.status   = ST_OK;
                  rsp_in.full_res = src_full;
                  rsp_in.tape_out = src_full ? rd_tape_ff : '0;
               end
            end
            default: rsp_in.status = ST_INVAL;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         full_ff      <= full_in;
         rsp_valid_ff <= ctl.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[src/media_changer_element_table_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// media_changer_element_table_top - media changer element table
// Occupancy table of slots, drives and mailslots with move, remove, place,
// clear and query commands; one result per command.
// ----------------------------------------------------------------------------
// Timing: the start transfer captures the request and reads the table;
//   the execute state does the read-modify-write; the result and its strobe
//   are registered. New commands are taken only while idle (busy low).
// Reset: synchronous, active high; empties the table and restores the
//   element counts to 64/8/8. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module media_changer_element_table_top
   import mcet_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   // result channel: one-cycle strobe
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   // configuration write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ctl_type ctl;

   // sequencer: idle -> execute -> idle
   mcet_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl)
   );

   // decode, table storage and result register
   mcet_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
